[rtl/pac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pac_pkg;

	// Number of quotient bits, one divider cell per bit
	localparam int DIV_STEPS = 8;

	// Configuration register indexes
	localparam logic [1:0] CFG_UNMULT  = 2'd0;
	localparam logic [1:0] CFG_KEY     = 2'd1;
	localparam logic [1:0] CFG_REPLACE = 2'd2;
	localparam logic [1:0] CFG_CUTOFF  = 2'd3;

	// Input pixel
	typedef struct packed {
		logic [7:0] alpha_in;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pix_in_t;

	// Result pixel
	typedef struct packed {
		logic [7:0] alpha_out;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} pix_out_t;

	// Register file contents
	typedef struct packed {
		logic        unmult_enable;
		logic [31:0] key_color;
		logic [31:0] replace_color;
		logic [7:0]  alpha_cutoff;
	} cfg_t;

	// Per color channel division state
	typedef struct packed {
		logic [7:0]  color;  // original color byte
		logic        zero;   // numerator not positive
		logic        sat;    // quotient above 255
		logic [15:0] rem;    // running remainder
		logic [7:0]  quo;    // quotient bits so far
	} chan_t;

	// Item handed from cell to cell; ch[2] red, ch[1] green, ch[0] blue
	typedef struct packed {
		logic [7:0]       alpha;
		logic             bypass;
		logic [15:0]      dvs;    // alpha aligned to the current quotient bit
		chan_t [2:0]      ch;
	} div_t;

endpackage

`default_nettype wire

[rtl/pac_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pac_front import pac_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    unmult_enable,
	input  wire logic    up_valid,
	output logic         up_ready,
	input  wire pix_in_t up_data,
	output logic         dn_valid,
	input  wire logic    dn_ready,
	output div_t         dn_data
);

	logic [2:0][7:0] col;
	logic [2:0][8:0] sum;
	logic [2:0][7:0] nval;
	div_t            nxt;
	logic            vld_q;
	div_t            data_q;

	assign col = {up_data.red_in, up_data.green_in, up_data.blue_in};

	// Form numerator (C+A-255)*255 and flag the clamp cases
	always_comb begin
		nxt.alpha  = up_data.alpha_in;
		nxt.bypass = ~unmult_enable | (up_data.alpha_in == 8'd0) |
			(up_data.alpha_in == 8'hFF);
		nxt.dvs    = {1'b0, up_data.alpha_in, 7'd0};
		for (int i = 0; i < 3; i++) begin
			sum[i]            = {1'b0, col[i]} + {1'b0, up_data.alpha_in};
			nval[i]           = sum[i][7:0] + 8'd1;
			nxt.ch[i].color   = col[i];
			nxt.ch[i].zero    = ~sum[i][8];
			nxt.ch[i].rem     = {nval[i], 8'd0} - {8'd0, nval[i]};
			nxt.ch[i].sat     = (nxt.ch[i].rem >= {up_data.alpha_in, 8'd0});
			nxt.ch[i].quo     = '0;
		end
	end

	assign up_ready = ~vld_q | dn_ready;
	assign dn_valid = vld_q;
	assign dn_data  = data_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	// Load payload on transfer
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/pac_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module pac_div_cell import pac_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic up_valid,
	output logic      up_ready,
	input  wire div_t up_data,
	output logic      dn_valid,
	input  wire logic dn_ready,
	output div_t      dn_data
);

	div_t nxt;
	logic vld_q;
	div_t data_q;

	// Resolve one quotient bit per channel, then align divisor to the next bit
	always_comb begin
		nxt     = up_data;
		nxt.dvs = {1'b0, up_data.dvs[15:1]};
		for (int i = 0; i < 3; i++) begin
			if (up_data.ch[i].rem >= up_data.dvs) begin
				nxt.ch[i].rem = up_data.ch[i].rem - up_data.dvs;
				nxt.ch[i].quo = {up_data.ch[i].quo[6:0], 1'b1};
			end else begin
				nxt.ch[i].quo = {up_data.ch[i].quo[6:0], 1'b0};
			end
		end
	end

	assign up_ready = ~vld_q | dn_ready;
	assign dn_valid = vld_q;
	assign dn_data  = data_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	// Load payload on transfer
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/pac_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pac_back import pac_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic up_valid,
	output logic      up_ready,
	input  wire div_t up_data,
	output logic      res_valid,
	input  wire logic res_stall,
	output pix_out_t  res
);

	logic [2:0][7:0] chan;
	logic [31:0]     pix;
	logic [7:0]      alpha;
	pix_out_t        nxt;
	logic            vld_q;
	pix_out_t        data_q;

	// Pick unpremultiplied color, apply key replacement and alpha cutoff
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (up_data.bypass) begin
				chan[i] = up_data.ch[i].color;
			end else if (up_data.ch[i].zero) begin
				chan[i] = 8'd0;
			end else if (up_data.ch[i].sat) begin
				chan[i] = 8'hFF;
			end else begin
				chan[i] = up_data.ch[i].quo;
			end
		end
		pix = {up_data.alpha, chan[2], chan[1], chan[0]};
		if (pix == cfg.key_color) begin
			pix = cfg.replace_color;
		end
		alpha = pix[31:24];
		if ((cfg.alpha_cutoff != 8'd0) && (alpha <= cfg.alpha_cutoff)) begin
			alpha = 8'd0;
		end
		nxt.alpha_out = alpha;
		nxt.red_out   = pix[23:16];
		nxt.green_out = pix[15:8];
		nxt.blue_out  = pix[7:0];
	end

	assign up_ready  = ~vld_q | ~res_stall;
	assign res_valid = vld_q;
	assign res       = data_q;

	// Track output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	// Load result on transfer
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/pixel_alpha_cleanup_top.sv]
// Path: a pixel transferred in passes through the front cell, eight divider
// cells resolving one quotient bit each, and the output register, then on res.
// Throughput: one pixel per cycle without res_stall; each cell advances when it may.
// Reset: arst_n clears all cell occupancy and sets the configuration registers
// to 0; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module pixel_alpha_cleanup_top import pac_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        px_valid,
	output logic             px_stall,
	input  wire pix_in_t     px,
	output logic             res_valid,
	input  wire logic        res_stall,
	output pix_out_t         res,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t                 cfg_q;
	logic                 front_ready;
	logic [DIV_STEPS:0]   lnk_valid;
	logic [DIV_STEPS:0]   lnk_ready;
	div_t                 lnk_data [DIV_STEPS+1];

	// Register writes are always accepted and registered in cfg_q
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_UNMULT:  cfg_q.unmult_enable <= cfg_data[0];
				CFG_KEY:     cfg_q.key_color     <= cfg_data;
				CFG_REPLACE: cfg_q.replace_color <= cfg_data;
				CFG_CUTOFF:  cfg_q.alpha_cutoff  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign px_stall = ~front_ready;

	pac_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.unmult_enable (cfg_q.unmult_enable),
		.up_valid      (px_valid),
		.up_ready      (front_ready),
		.up_data       (px),
		.dn_valid      (lnk_valid[0]),
		.dn_ready      (lnk_ready[0]),
		.dn_data       (lnk_data[0])
	);

	// Divider chain, most significant quotient bit first
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
		pac_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (lnk_valid[k]),
			.up_ready (lnk_ready[k]),
			.up_data  (lnk_data[k]),
			.dn_valid (lnk_valid[k+1]),
			.dn_ready (lnk_ready[k+1]),
			.dn_data  (lnk_data[k+1])
		);
	end

	pac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.up_valid  (lnk_valid[DIV_STEPS]),
		.up_ready  (lnk_ready[DIV_STEPS]),
		.up_data   (lnk_data[DIV_STEPS]),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire
